>>> hw/rtl/single_tone_iq_correlator_macros.svh
// Assertion macros for the single-tone IQ correlator.
// Included by the RTL files that carry concurrent checks; needs no other file.
`ifndef SINGLE_TONE_IQ_CORRELATOR_MACROS_SVH
`define SINGLE_TONE_IQ_CORRELATOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define STIC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define STIC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STIC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define STIC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

>>> hw/rtl/stic_pkg.sv
// Shared constants, types and the quarter-wave reference tables of the correlator.
// No dependencies; used by stic_sat_acc and single_tone_iq_correlator.
`timescale 1ns / 1ps
`default_nettype none

package stic_pkg;

  localparam int MAX_FRAMES  = 16384;
  localparam int TABLE_DEPTH = 1024;

  localparam int TAB_BITS  = $clog2(TABLE_DEPTH);
  localparam int QTR_DEPTH = TABLE_DEPTH / 4;
  localparam int QTR_BITS  = TAB_BITS - 2;
  localparam int FCNT_W    = $clog2(MAX_FRAMES + 1);

  localparam int PHASE_W  = 32;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;
  localparam int REF_W    = 16;
  localparam int PROD_W   = SAMPLE_W + REF_W;
  localparam int SUM_W    = 48;

  // Angles in Q30 radians.
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint REF_SCALE   = 64'sd32767;

  typedef enum logic [1:0] {
    QTR_0 = 2'd0,
    QTR_1 = 2'd1,
    QTR_2 = 2'd2,
    QTR_3 = 2'd3
  } quadrant_t;

  typedef struct packed {
    logic fire;
    logic add_en;
    logic clear;
  } acc_ctrl_t;

  typedef logic [MAG_W-1:0] qtr_tab_t [QTR_DEPTH];

  // Scaled sine magnitude for an angle in [0, pi), Taylor series through x^15.
  function automatic logic [MAG_W-1:0] sine_mag(input longint angle);
    longint x;
    longint term;
    longint sum;
    longint s;
    x = angle;
    if (x > Q30_HALF_PI) begin
      x = Q30_PI - x;
    end
    term = x;
    sum  = x;
    term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 64'sd6;
    sum  = sum - term;
    term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 64'sd20;
    sum  = sum + term;
    term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 64'sd42;
    sum  = sum - term;
    term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 64'sd72;
    sum  = sum + term;
    term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 64'sd110;
    sum  = sum - term;
    term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 64'sd156;
    sum  = sum + term;
    term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 64'sd210;
    sum  = sum - term;
    if (sum < 0) begin
      sum = 0;
    end
    s = (sum * REF_SCALE + (64'sd1 <<< 29)) >>> 30;
    if (s > REF_SCALE) begin
      s = REF_SCALE;
    end
    return s[MAG_W-1:0];
  endfunction

  // One quarter of the full-cycle table, starting at entry first.
  function automatic qtr_tab_t build_qtr(input int first);
    qtr_tab_t t;
    longint   base;
    int       l;
    for (l = 0; l < QTR_DEPTH; l++) begin
      base = ((longint'(l) + longint'(first)) * Q30_TWO_PI) / TABLE_DEPTH;
      t[l] = sine_mag(base);
    end
    return t;
  endfunction

  // Rising quarter and falling quarter of the positive half cycle.
  localparam qtr_tab_t QTR_RISE = build_qtr(0);
  localparam qtr_tab_t QTR_FALL = build_qtr(QTR_DEPTH);

endpackage

`default_nettype wire

>>> hw/rtl/stic_sat_acc.sv
// Saturating 48-bit accumulator for one correlation product lane.
// Depends on stic_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "single_tone_iq_correlator_macros.svh"

module stic_sat_acc (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire stic_pkg::acc_ctrl_t                     ctrl,
  input  wire logic signed [stic_pkg::PROD_W-1:0]      prod,
  output logic signed [stic_pkg::SUM_W-1:0]            total
);

  logic signed [stic_pkg::SUM_W-1:0] acc_r;
  logic signed [stic_pkg::SUM_W-1:0] acc_nxt;
  logic signed [stic_pkg::SUM_W:0]   wide;
  logic signed [stic_pkg::SUM_W:0]   addend;

  localparam logic signed [stic_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(stic_pkg::SUM_W-1){1'b1}}};
  localparam logic signed [stic_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(stic_pkg::SUM_W-1){1'b0}}};

  always_comb begin
    addend = ctrl.add_en ? (stic_pkg::SUM_W+1)'(prod) : '0;
    wide   = (stic_pkg::SUM_W+1)'(acc_r) + addend;
    // The two top bits differ only when the true sum left the 48-bit range.
    if (wide[stic_pkg::SUM_W] != wide[stic_pkg::SUM_W-1]) begin
      total = wide[stic_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      total = wide[stic_pkg::SUM_W-1:0];
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.fire) begin
      acc_nxt = ctrl.clear ? '0 : total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  `STIC_ASSERT_NXT(a_clear_after_last, clk, rst_n, ctrl.fire && ctrl.clear, acc_r == '0,
                   "accumulator not cleared after the last item of a buffer")
  `STIC_ASSERT_IMP(a_no_wrap_up, clk, rst_n,
                   ctrl.fire && ctrl.add_en && !prod[stic_pkg::PROD_W-1]
                   && !acc_r[stic_pkg::SUM_W-1],
                   !total[stic_pkg::SUM_W-1], "positive sum wrapped negative")

endmodule

`default_nettype wire

>>> hw/rtl/single_tone_iq_correlator.sv
// Single-tone IQ correlator top level: phase, reference lookup, multiply, accumulate.
// Depends on stic_pkg, stic_sat_acc and the assertion macro header.
//
// Usage:
//   Input channel in_valid / in_stall carries one signed 16-bit sample per item
//   plus in_last, which marks the final sample of a buffer. Items are accepted
//   on any cycle in which in_valid is high and in_stall is low; the block takes
//   one item per cycle for a continuous stream while in_stall stays low.
//   Each item passes three register stages: phase-indexed quarter-table read,
//   the two 16x16 multiplies, then the saturating accumulators. The result item
//   (out_sin_sum, out_cos_sum) shows on out_valid once the last item of a buffer
//   leaves stage 2; the sums then restart from zero. The output register holds a
//   result while out_stall is high. Samples that are not last keep flowing
//   meanwhile; in_stall rises only when a last item reaches the accumulators while
//   the previous result is still waiting. Synchronous active-low reset clears the
//   phase, frame count, sums, the phase step register and all valid flags. cfg_we
//   writes cfg_phase_step; the user must do so only while idle, unchecked by the block.
`timescale 1ns / 1ps
`default_nettype none

`include "single_tone_iq_correlator_macros.svh"

module single_tone_iq_correlator (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [stic_pkg::PHASE_W-1:0]          cfg_phase_step,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [stic_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic                                  in_last,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [stic_pkg::SUM_W-1:0]          out_sin_sum,
  output logic signed [stic_pkg::SUM_W-1:0]          out_cos_sum
);

  // Configuration and per-buffer state.
  logic [stic_pkg::PHASE_W-1:0] phase_step_r;
  logic [stic_pkg::PHASE_W-1:0] phase_acc_r;
  logic [stic_pkg::PHASE_W-1:0] phase_acc_nxt;
  logic [stic_pkg::FCNT_W-1:0]  frame_cnt_r;
  logic [stic_pkg::FCNT_W-1:0]  frame_cnt_nxt;

  logic                            accept;
  logic                            hold;
  logic                            in_window;
  logic [stic_pkg::TAB_BITS-1:0]   tab_idx;
  logic [stic_pkg::QTR_BITS-1:0]   qtr_idx;

  // Stage 1: table values.
  logic                              s1_valid_r;
  logic                              s1_last_r;
  logic                              s1_en_r;
  logic signed [stic_pkg::SAMPLE_W-1:0] s1_sample_r;
  stic_pkg::quadrant_t               s1_qtr_r;
  logic [stic_pkg::MAG_W-1:0]        s1_rise_r;
  logic [stic_pkg::MAG_W-1:0]        s1_fall_r;

  // Stage 2: products.
  logic                              s2_valid_r;
  logic                              s2_last_r;
  logic                              s2_en_r;
  logic signed [stic_pkg::PROD_W-1:0] s2_psin_r;
  logic signed [stic_pkg::PROD_W-1:0] s2_pcos_r;

  logic signed [stic_pkg::REF_W-1:0]  ref_sin;
  logic signed [stic_pkg::REF_W-1:0]  ref_cos;
  logic signed [stic_pkg::REF_W-1:0]  rise_s;
  logic signed [stic_pkg::REF_W-1:0]  fall_s;

  stic_pkg::acc_ctrl_t               acc_ctrl;
  logic signed [stic_pkg::SUM_W-1:0] sin_total;
  logic signed [stic_pkg::SUM_W-1:0] cos_total;
  logic                              s2_fire;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic signed [stic_pkg::SUM_W-1:0] out_sin_r;
  logic signed [stic_pkg::SUM_W-1:0] out_cos_r;

  assign hold     = s2_valid_r && s2_last_r && out_valid_r && out_stall;
  assign in_stall = hold;
  assign accept   = in_valid && !hold;
  assign s2_fire  = s2_valid_r && !hold;

  assign tab_idx   = phase_acc_r[stic_pkg::PHASE_W-1 -: stic_pkg::TAB_BITS];
  assign qtr_idx   = tab_idx[stic_pkg::QTR_BITS-1:0];
  assign in_window = frame_cnt_r < stic_pkg::FCNT_W'(stic_pkg::MAX_FRAMES);

  always_comb begin
    phase_acc_nxt = phase_acc_r;
    frame_cnt_nxt = frame_cnt_r;
    if (accept) begin
      if (in_last) begin
        phase_acc_nxt = '0;
        frame_cnt_nxt = '0;
      end else begin
        phase_acc_nxt = phase_acc_r + phase_step_r;
        frame_cnt_nxt = in_window ? frame_cnt_r + 1'b1 : frame_cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      phase_acc_r  <= '0;
      frame_cnt_r  <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        phase_step_r <= cfg_phase_step;
      end
      phase_acc_r <= phase_acc_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      if (!hold) begin
        s1_valid_r <= accept;
        s2_valid_r <= s1_valid_r;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage 1 payload: both quarter tables are read at the same low index.
  always_ff @(posedge clk) begin
    if (!hold) begin
      s1_last_r   <= in_last;
      s1_en_r     <= in_window;
      s1_sample_r <= in_sample;
      s1_qtr_r    <= stic_pkg::quadrant_t'(tab_idx[stic_pkg::TAB_BITS-1 -: 2]);
      s1_rise_r   <= stic_pkg::QTR_RISE[qtr_idx];
      s1_fall_r   <= stic_pkg::QTR_FALL[qtr_idx];
    end
  end

  // The reference sits half a cycle ahead and the cosine a further quarter,
  // so each tone quarter maps to one table, its partner and a sign.
  assign rise_s = stic_pkg::REF_W'({1'b0, s1_rise_r});
  assign fall_s = stic_pkg::REF_W'({1'b0, s1_fall_r});

  always_comb begin
    ref_sin = '0;
    ref_cos = '0;
    case (s1_qtr_r)
      stic_pkg::QTR_0: begin
        ref_sin = -rise_s;
        ref_cos = -fall_s;
      end
      stic_pkg::QTR_1: begin
        ref_sin = -fall_s;
        ref_cos = rise_s;
      end
      stic_pkg::QTR_2: begin
        ref_sin = rise_s;
        ref_cos = fall_s;
      end
      stic_pkg::QTR_3: begin
        ref_sin = fall_s;
        ref_cos = -rise_s;
      end
      default: begin
        ref_sin = '0;
        ref_cos = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s2_last_r <= s1_last_r;
      s2_en_r   <= s1_en_r;
      s2_psin_r <= stic_pkg::PROD_W'(s1_sample_r) * stic_pkg::PROD_W'(ref_sin);
      s2_pcos_r <= stic_pkg::PROD_W'(s1_sample_r) * stic_pkg::PROD_W'(ref_cos);
    end
  end

  assign acc_ctrl.fire   = s2_fire;
  assign acc_ctrl.add_en = s2_en_r;
  assign acc_ctrl.clear  = s2_last_r;

  stic_sat_acc u_sin_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (acc_ctrl),
    .prod  (s2_psin_r),
    .total (sin_total)
  );

  stic_sat_acc u_cos_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (acc_ctrl),
    .prod  (s2_pcos_r),
    .total (cos_total)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_fire && s2_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_last_r) begin
      out_sin_r <= sin_total;
      out_cos_r <= cos_total;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_sin_sum = out_sin_r;
  assign out_cos_sum = out_cos_r;

  `STIC_ASSERT_IMP(a_frame_cnt_bound, clk, rst_n, 1'b1,
                   frame_cnt_r <= stic_pkg::FCNT_W'(stic_pkg::MAX_FRAMES),
                   "frame count ran past the frame limit")
  `STIC_ASSERT_NXT(a_phase_restart, clk, rst_n, accept && in_last, phase_acc_r == '0,
                   "phase did not restart after the last item of a buffer")
  `STIC_ASSERT_IMP(a_stall_needs_result, clk, rst_n, !s2_valid_r || !out_valid_r,
                   !in_stall, "input stalled with no waiting result to block it")

endmodule

`default_nettype wire
